[sv/ncd_pkg.sv]
// Package for the chunk deframer: result item type, result kinds, markers.
// Used by ncd_rq.sv, nsv_chunk_deframer.sv and tb_top.sv; depends on nothing.
package ncd_pkg;

	// log2 of the result queue depth (queue must hold at least four items)
	localparam int unsigned NCD_RQ_LOG2 = 2;

	// result kinds
	localparam logic [2:0] KIND_VIDEO_START = 3'd0;
	localparam logic [2:0] KIND_AUDIO_START = 3'd1;
	localparam logic [2:0] KIND_VIDEO_BYTE  = 3'd2;
	localparam logic [2:0] KIND_AUDIO_BYTE  = 3'd3;
	localparam logic [2:0] KIND_SYNC_LOST   = 3'd4;

	// configuration register indexes
	localparam logic CFG_VIDEO_PRESENT = 1'b0;
	localparam logic CFG_AUDIO_PRESENT = 1'b1;

	// header markers
	localparam logic [15:0] MARK_CHUNK    = 16'h4E53;
	localparam logic [15:0] MARK_SHORT    = 16'hEFBE;
	localparam logic [7:0]  MARK_SYNC_B2  = 8'h56;
	localparam logic [7:0]  MARK_SYNC_B3  = 8'h73;

	// byte counts of the fixed sections
	localparam logic [4:0] HDR_LEN    = 5'd7;
	localparam logic [4:0] SKIP_LEN   = 5'd10;
	localparam logic [4:0] AUXHDR_LEN = 5'd6;

	// one result item
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  payload_byte;
		logic [19:0] packet_length;
		logic [31:0] frame_number;
		logic        last_of_packet;
	} result_t;

	function automatic result_t make_result(logic [2:0] kind, logic [7:0] byte_v,
	                                        logic [19:0] len, logic [31:0] frame,
	                                        logic last);
		result_t r;
		r.kind           = kind;
		r.payload_byte   = byte_v;
		r.packet_length  = len;
		r.frame_number   = frame;
		r.last_of_packet = last;
		return r;
	endfunction

endpackage

[sv/ncd_rq.sv]
// Result queue of the chunk deframer: takes up to three items per cycle,
// hands out one per cycle while pop is high. Depends on ncd_pkg.
module ncd_rq import ncd_pkg::*; #(
	parameter int unsigned LOG2 = NCD_RQ_LOG2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    push_cnt,
	input  result_t [2:0] push_data,
	input  logic          pop,
	output result_t       head,
	output logic          not_empty,
	output logic          room
);

	localparam int unsigned DEPTH = 1 << LOG2;

	result_t          mem_q [DEPTH];
	logic [LOG2-1:0]  wr_q;
	logic [LOG2-1:0]  rd_q;
	logic [LOG2:0]    count_q;
	logic             do_pop;

	assign not_empty = (count_q != '0);
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_q];
	// room for a worst-case byte (three items)
	assign room      = (count_q <= (LOG2+1)'(DEPTH - 3));

	// storage
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (2'(k) < push_cnt) begin
				mem_q[wr_q + LOG2'(k)] <= push_data[k];
			end
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + LOG2'(push_cnt);
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			count_q <= count_q + (LOG2+1)'(push_cnt) - (LOG2+1)'(do_pop);
		end
	end

endmodule

[sv/nsv_chunk_deframer.sv]
// Chunk deframer: splits a container byte stream into video/audio packet items.
// Each taken byte writes its results into the result queue; the output is its head.
// Throughput: one byte per cycle; a byte makes at most three results, and the input
// stalls while the result queue has fewer than three free slots, so the output drain
// rate (one result per cycle) bounds bursts of multi-result bytes.
// Reset: control state, lengths and frame counter clear; both present bits set to 1.
module nsv_chunk_deframer import ncd_pkg::*; #(
	parameter int unsigned RQ_LOG2 = NCD_RQ_LOG2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_kind,
	output logic [7:0]  payload_byte,
	output logic [19:0] packet_length,
	output logic [31:0] frame_number,
	output logic        last_of_packet,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data
);

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_SKIP10  = 3'd1,
		PH_HEADER2 = 3'd2,
		PH_AUXHDR  = 3'd3,
		PH_AUXSKIP = 3'd4,
		PH_VIDEO   = 3'd5,
		PH_AUDIO   = 3'd6
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [4:0]  pc_q, pc_n;
	logic [7:0]  hb_q [7];
	logic [15:0] aux_q, aux_n;
	logic [19:0] vrem_q, vrem_n;
	logic [15:0] arem_q, arem_n;
	logic [31:0] cc_q, cc_n;
	logic        vp_q, ap_q;

	logic          accept;
	logic [1:0]    n_res;
	result_t [2:0] res;
	result_t       head;
	logic          rq_valid, rq_room;

	assign accept   = in_valid && !in_stall;
	assign in_stall = !rq_room;

	// per-byte state update and result generation
	always_comb begin
		logic        sv, sa, use_hdr;
		logic [7:0]  h2, h3, h4, h5, h6;
		logic [16:0] sub;
		sv = 1'b0; sa = 1'b0; use_hdr = 1'b0;
		phase_n = phase_q; pc_n = pc_q; aux_n = aux_q;
		vrem_n = vrem_q; arem_n = arem_q; cc_n = cc_q;
		n_res = 2'd0;
		res   = '0;
		h2 = hb_q[2]; h3 = hb_q[3]; h4 = hb_q[4]; h5 = hb_q[5]; h6 = data_byte;
		sub = 17'd0;
		case (phase_q)
			PH_HEADER, PH_HEADER2: begin
				pc_n = pc_q + 5'd1;
				if (pc_n >= HDR_LEN) begin
					pc_n    = 5'd0;
					use_hdr = 1'b1;
					if (phase_q == PH_HEADER) begin
						if ({hb_q[0], hb_q[1]} == MARK_CHUNK) begin
							if (h2 == MARK_SYNC_B2 && h3 == MARK_SYNC_B3) begin
								phase_n = PH_SKIP10;
								use_hdr = 1'b0;
							end
						end else if ({hb_q[0], hb_q[1]} != MARK_SHORT) begin
							res[n_res] = make_result(KIND_SYNC_LOST, 8'd0, 20'd0, cc_q, 1'b0);
							n_res = n_res + 2'd1;
						end
					end
				end
			end
			PH_SKIP10: begin
				pc_n = pc_q + 5'd1;
				if (pc_n >= SKIP_LEN) begin
					pc_n    = 5'd0;
					phase_n = PH_HEADER2;
				end
			end
			PH_AUXHDR: begin
				if (pc_q == 5'd0) begin
					aux_n = {8'd0, data_byte};
				end else if (pc_q == 5'd1) begin
					aux_n = {data_byte, aux_q[7:0]};
				end
				pc_n = pc_q + 5'd1;
				if (pc_n >= AUXHDR_LEN) begin
					pc_n   = 5'd0;
					sub    = {1'b0, aux_n} + 17'd6;
					vrem_n = (vrem_q > {3'd0, sub}) ? vrem_q - {3'd0, sub} : 20'd0;
					if (aux_n == 16'd0) begin
						sv = 1'b1;
					end else begin
						phase_n = PH_AUXSKIP;
					end
				end
			end
			PH_AUXSKIP: begin
				if (aux_q != 16'd0) begin
					aux_n = aux_q - 16'd1;
				end
				if (aux_n == 16'd0) begin
					sv = 1'b1;
				end
			end
			PH_VIDEO: begin
				if (vp_q) begin
					res[n_res] = make_result(KIND_VIDEO_BYTE, data_byte, 20'd0, cc_q,
					                         vrem_q == 20'd1);
					n_res = n_res + 2'd1;
				end
				if (vrem_q != 20'd0) begin
					vrem_n = vrem_q - 20'd1;
				end
				if (vrem_n == 20'd0) begin
					sa = 1'b1;
				end
			end
			PH_AUDIO: begin
				if (ap_q) begin
					res[n_res] = make_result(KIND_AUDIO_BYTE, data_byte, 20'd0, cc_q,
					                         arem_q == 16'd1);
					n_res = n_res + 2'd1;
				end
				if (arem_q != 16'd0) begin
					arem_n = arem_q - 16'd1;
				end
				if (arem_n == 16'd0) begin
					cc_n    = cc_q + 32'd1;
					phase_n = PH_HEADER;
					pc_n    = 5'd0;
				end
			end
			default: begin
				phase_n = PH_HEADER;
				pc_n    = 5'd0;
			end
		endcase
		// decode a completed header
		if (use_hdr) begin
			vrem_n = {h4, h3, h2[7:4]};
			arem_n = {h6, h5};
			if (h2[3:0] != 4'd0) begin
				phase_n = PH_AUXHDR;
				pc_n    = 5'd0;
			end else begin
				sv = 1'b1;
			end
		end
		// video packet start
		if (sv) begin
			if (vp_q) begin
				res[n_res] = make_result(KIND_VIDEO_START, 8'd0, vrem_n, cc_q, 1'b0);
				n_res = n_res + 2'd1;
			end
			if (vrem_n == 20'd0) begin
				sa = 1'b1;
			end else begin
				phase_n = PH_VIDEO;
			end
		end
		// audio packet start
		if (sa) begin
			if (ap_q) begin
				res[n_res] = make_result(KIND_AUDIO_START, 8'd0, {4'd0, arem_n}, cc_q, 1'b0);
				n_res = n_res + 2'd1;
			end
			if (arem_n == 16'd0) begin
				cc_n    = cc_q + 32'd1;
				phase_n = PH_HEADER;
				pc_n    = 5'd0;
			end else begin
				phase_n = PH_AUDIO;
			end
		end
	end

	// header byte store
	always_ff @(posedge clk) begin
		if (accept && (phase_q == PH_HEADER || phase_q == PH_HEADER2) && pc_q < HDR_LEN) begin
			hb_q[pc_q[2:0]] <= data_byte;
		end
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pc_q    <= 5'd0;
			aux_q   <= 16'd0;
			vrem_q  <= 20'd0;
			arem_q  <= 16'd0;
			cc_q    <= 32'd0;
			vp_q    <= 1'b1;
			ap_q    <= 1'b1;
		end else begin
			if (accept) begin
				phase_q <= phase_n;
				pc_q    <= pc_n;
				aux_q   <= aux_n;
				vrem_q  <= vrem_n;
				arem_q  <= arem_n;
				cc_q    <= cc_n;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_VIDEO_PRESENT: vp_q <= cfg_data;
					CFG_AUDIO_PRESENT: ap_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	ncd_rq #(
		.LOG2(RQ_LOG2)
	) u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (accept ? n_res : 2'd0),
		.push_data (res),
		.pop       (!out_stall),
		.head      (head),
		.not_empty (rq_valid),
		.room      (rq_room)
	);

	assign out_valid      = rq_valid;
	assign result_kind    = head.kind;
	assign payload_byte   = head.payload_byte;
	assign packet_length  = head.packet_length;
	assign frame_number   = head.frame_number;
	assign last_of_packet = head.last_of_packet;

`ifndef NO_ASSERTIONS
	// payload phases never sit with nothing left to move
	a_video_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_VIDEO |-> vrem_q != 20'd0)
		else $error("video phase with zero remaining");
	a_audio_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_AUDIO |-> arem_q != 16'd0)
		else $error("audio phase with zero remaining");
	a_auxskip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_AUXSKIP |-> aux_q != 16'd0)
		else $error("aux skip with zero remaining");
	// header byte index stays inside the header
	a_hdr_index: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEADER || phase_q == PH_HEADER2) |-> pc_q < HDR_LEN)
		else $error("header byte index out of range");
`endif

endmodule

[test/tb_top.sv]
// Testbench for nsv_chunk_deframer: feeds container byte streams built from chunks,
// predicts the packet items in a behavioral model and checks every output item.
// Depends on ncd_pkg (result type, kinds, markers) and the deframer RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ncd_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned RANDOM_BYTES = 170;
	localparam int unsigned NUM_SLICES   = 6;
	localparam int unsigned MAX_GAP      = 10;
	localparam int unsigned LONG_HOLD    = 150;
	localparam int unsigned HOLD_TRIGGER = 60;
	localparam int unsigned MAX_REPORTS  = 10;
	localparam int unsigned MAX_PER_BYTE = 3;

	// deframer phases of the predictor
	typedef enum logic [2:0] {
		DF_HEADER, DF_SKIP, DF_HEADER2, DF_AUXHDR, DF_AUXSKIP, DF_VIDEO, DF_AUDIO
	} deframe_phase_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  result_kind;
	logic [7:0]  payload_byte;
	logic [19:0] packet_length;
	logic [31:0] frame_number;
	logic        last_of_packet;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_VIDEO_PRESENT;
	logic        cfg_data = 1'b0;

	nsv_chunk_deframer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_kind(result_kind), .payload_byte(payload_byte),
		.packet_length(packet_length), .frame_number(frame_number),
		.last_of_packet(last_of_packet),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// predictor state and its copy of the presence registers
	deframe_phase_e df_phase = DF_HEADER;
	logic [4:0]     df_count = '0;
	logic [7:0]     hdr [0:6];
	logic [15:0]    aux_left = '0;
	logic [19:0]    vid_left = '0;
	logic [15:0]    aud_left = '0;
	logic [31:0]    frame_ctr = '0;
	logic           video_on = 1'b1;
	logic           audio_on = 1'b1;
	int unsigned    results_this_byte;

	result_t     expected_packets [$];
	logic [7:0]  stream_bytes [$];
	logic [7:0]  pending_bytes [$];
	int unsigned next_byte = 0;

	int unsigned bytes_taken = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned gap_left = 0;
	int unsigned hold_left = 0;
	int unsigned tx_mark = 0;
	int unsigned rx_mark = 0;
	bit          long_hold_done = 1'b0;
	bit          tx_bursty = 1'b0;
	bit          rx_bursty = 1'b0;

	function automatic void emit(logic [2:0] kind, logic [7:0] b, logic [19:0] len,
	                             logic last);
		result_t r;
		if (results_this_byte < MAX_PER_BYTE) begin
			r.kind           = kind;
			r.payload_byte   = b;
			r.packet_length  = len;
			r.frame_number   = frame_ctr;
			r.last_of_packet = last;
			expected_packets.push_back(r);
			results_this_byte++;
		end
	endfunction

	// audio start; an empty audio packet closes the chunk at once
	function automatic void open_audio();
		if (audio_on)
			emit(KIND_AUDIO_START, 8'h00, {4'h0, aud_left}, 1'b0);
		if (aud_left == 0) begin
			frame_ctr++;
			df_phase = DF_HEADER;
			df_count = '0;
		end else begin
			df_phase = DF_AUDIO;
		end
	endfunction

	function automatic void open_video();
		if (video_on)
			emit(KIND_VIDEO_START, 8'h00, vid_left, 1'b0);
		if (vid_left == 0)
			open_audio();
		else
			df_phase = DF_VIDEO;
	endfunction

	// one byte through the predictor; expected items go to expected_packets
	function automatic void deframe_byte(logic [7:0] b);
		int unsigned aux_cost;
		bit use_hdr;
		results_this_byte = 0;
		case (df_phase)
			DF_HEADER, DF_HEADER2: begin
				hdr[df_count] = b;
				df_count++;
				if (df_count >= HDR_LEN) begin
					df_count = '0;
					use_hdr = 1'b1;
					if (df_phase == DF_HEADER) begin
						if ({hdr[0], hdr[1]} == MARK_CHUNK) begin
							if (hdr[2] == MARK_SYNC_B2 && hdr[3] == MARK_SYNC_B3) begin
								df_phase = DF_SKIP;
								use_hdr = 1'b0;
							end
						end else if ({hdr[0], hdr[1]} != MARK_SHORT) begin
							emit(KIND_SYNC_LOST, 8'h00, 20'h0, 1'b0);
						end
					end
					if (use_hdr) begin
						vid_left = {hdr[4], hdr[3], hdr[2][7:4]};
						aud_left = {hdr[6], hdr[5]};
						if (hdr[2][3:0] != 4'h0) begin
							df_phase = DF_AUXHDR;
							df_count = '0;
						end else begin
							open_video();
						end
					end
				end
			end
			DF_SKIP: begin
				df_count++;
				if (df_count >= SKIP_LEN) begin
					df_count = '0;
					df_phase = DF_HEADER2;
				end
			end
			DF_AUXHDR: begin
				if (df_count == 0)
					aux_left = {8'h00, b};
				else if (df_count == 1)
					aux_left[15:8] = b;
				df_count++;
				if (df_count >= AUXHDR_LEN) begin
					aux_cost = aux_left + 6;
					df_count = '0;
					vid_left = (vid_left > aux_cost) ? 20'(vid_left - aux_cost) : 20'h0;
					if (aux_left == 0)
						open_video();
					else
						df_phase = DF_AUXSKIP;
				end
			end
			DF_AUXSKIP: begin
				if (aux_left > 0)
					aux_left--;
				if (aux_left == 0)
					open_video();
			end
			DF_VIDEO: begin
				if (video_on)
					emit(KIND_VIDEO_BYTE, b, 20'h0, vid_left == 1);
				if (vid_left > 0)
					vid_left--;
				if (vid_left == 0)
					open_audio();
			end
			DF_AUDIO: begin
				if (audio_on)
					emit(KIND_AUDIO_BYTE, b, 20'h0, aud_left == 1);
				if (aud_left > 0)
					aud_left--;
				if (aud_left == 0) begin
					frame_ctr++;
					df_phase = DF_HEADER;
					df_count = '0;
				end
			end
			default: begin
				df_phase = DF_HEADER;
				df_count = '0;
			end
		endcase
	endfunction

	// stream building
	task automatic push_header(logic [15:0] mark, logic [19:0] vlen, logic [15:0] alen,
	                           logic [3:0] aux_nib);
		stream_bytes.push_back(mark[15:8]);
		stream_bytes.push_back(mark[7:0]);
		stream_bytes.push_back({vlen[3:0], aux_nib});
		stream_bytes.push_back(vlen[11:4]);
		stream_bytes.push_back(vlen[19:12]);
		stream_bytes.push_back(alen[7:0]);
		stream_bytes.push_back(alen[15:8]);
	endtask

	// one whole chunk, optionally behind a full sync header and its dropped bytes
	task automatic add_chunk(logic [15:0] mark, bit via_sync, logic [19:0] vlen,
	                         logic [15:0] alen, logic [3:0] aux_nib, logic [15:0] aux_size);
		int vid_bytes;
		if (via_sync) begin
			stream_bytes.push_back(MARK_CHUNK[15:8]);
			stream_bytes.push_back(MARK_CHUNK[7:0]);
			stream_bytes.push_back(MARK_SYNC_B2);
			stream_bytes.push_back(MARK_SYNC_B3);
			repeat (3 + SKIP_LEN) stream_bytes.push_back(8'($urandom));
		end
		push_header(mark, vlen, alen, aux_nib);
		vid_bytes = vlen;
		if (aux_nib != 4'h0) begin
			stream_bytes.push_back(aux_size[7:0]);
			stream_bytes.push_back(aux_size[15:8]);
			repeat (AUXHDR_LEN - 2) stream_bytes.push_back(8'($urandom));
			repeat (aux_size) stream_bytes.push_back(8'($urandom));
			vid_bytes = (vlen > aux_size + 6) ? vlen - aux_size - 6 : 0;
		end
		repeat (vid_bytes) stream_bytes.push_back(8'($urandom));
		repeat (alen) stream_bytes.push_back(8'($urandom));
	endtask

	task automatic feed_until(int unsigned upto);
		while (next_byte < upto) begin
			pending_bytes.push_back(stream_bytes[next_byte]);
			next_byte++;
		end
	endtask

	// wait until every byte is in and every expected item is out, then a little more
	task automatic settle(int unsigned extra);
		do @(posedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_packets.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	// both presence registers, written back to back while the block is idle
	task automatic set_presence(logic video_v, logic audio_v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_VIDEO_PRESENT;
		cfg_data  <= video_v;
		@(posedge clk);
		video_on = video_v;
		@(negedge clk);
		cfg_index <= CFG_AUDIO_PRESENT;
		cfg_data  <= audio_v;
		@(posedge clk);
		audio_on = audio_v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic report_mismatch(string what, result_t want, result_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$write("%s: expected kind %0d byte %02h len %0d frame %0d last %0d, ",
			       what, want.kind, want.payload_byte, want.packet_length,
			       want.frame_number, want.last_of_packet);
			$display("got kind %0d byte %02h len %0d frame %0d last %0d",
			         got.kind, got.payload_byte, got.packet_length,
			         got.frame_number, got.last_of_packet);
		end
	endtask

	// input side: sample accepted bytes and run them through the predictor
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			deframe_byte(data_byte);
			bytes_taken++;
		end
	end

	// driver: random gap before each item, then hold it until taken
	always @(negedge clk) begin : byte_driver
		logic next_valid;
		next_valid = in_valid;
		if (bytes_taken != tx_mark) begin
			tx_mark = bytes_taken;
			next_valid = 1'b0;
			gap_left = tx_bursty ? 0 : $urandom_range(0, MAX_GAP);
		end
		if (!next_valid) begin
			if (gap_left > 0)
				gap_left--;
			else if (pending_bytes.size() != 0) begin
				data_byte <= pending_bytes.pop_front();
				next_valid = 1'b1;
			end
		end
		in_valid <= next_valid;
	end

	// receiver: random stall per item, plus one long hold while bytes keep coming
	always @(negedge clk) begin
		if (results_seen != rx_mark) begin
			rx_mark = results_seen;
			hold_left = rx_bursty ? 0 : $urandom_range(0, MAX_GAP);
		end
		if (!long_hold_done && results_seen >= HOLD_TRIGGER && in_valid) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor: compare each accepted item with the oldest expectation
	always @(posedge clk) begin : item_monitor
		result_t got;
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			got.kind           = result_kind;
			got.payload_byte   = payload_byte;
			got.packet_length  = packet_length;
			got.frame_number   = frame_number;
			got.last_of_packet = last_of_packet;
			if (expected_packets.size() == 0) begin
				report_mismatch("unexpected item", '0, got);
			end else begin
				want = expected_packets.pop_front();
				if (got !== want)
					report_mismatch("item mismatch", want, got);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int unsigned directed_len;
		int unsigned random_end;
		int unsigned cut;
		int unsigned sel;
		logic [15:0] mark;
		logic [19:0] vlen;
		logic [15:0] alen;
		logic [3:0]  aux_nib;
		logic [15:0] aux_size;
		logic        v_on;
		logic        a_on;

		// directed: bad marker with both packets empty (three items from one byte),
		// then chunk marker without the sync pair where the aux eats all of the video
		add_chunk(16'hFFFF, 1'b0, 20'd0, 16'd0, 4'h0, 16'd0);
		add_chunk(MARK_CHUNK, 1'b0, 20'd3, 16'd1, 4'hF, 16'd1);
		directed_len = stream_bytes.size();

		// random chunks: mostly well formed, some with a broken marker
		while (stream_bytes.size() < directed_len + RANDOM_BYTES) begin
			sel      = $urandom_range(0, 9);
			vlen     = ($urandom_range(0, 4) == 0) ? 20'($urandom_range(0, 40))
			                                        : 20'($urandom_range(0, 8));
			alen     = 16'($urandom_range(0, 8));
			aux_nib  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : 4'h0;
			aux_size = 16'($urandom_range(0, 6));
			if (sel <= 3)
				mark = MARK_SHORT;
			else if (sel == 6)
				mark = MARK_CHUNK;
			else
				mark = 16'($urandom);
			add_chunk(mark, sel == 4 || sel == 5, vlen, alen, aux_nib, aux_size);
		end
		random_end = stream_bytes.size();

		// largest lengths; the run ends inside this video packet
		push_header(MARK_SHORT, 20'hFFFFF, 16'hFFFF, 4'h0);
		repeat (16) stream_bytes.push_back(8'($urandom));

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		set_presence(1'b1, 1'b1);
		feed_until(directed_len);
		settle(3);

		// random slices cut at arbitrary bytes, each under its own presence setting
		for (int k = 0; k < NUM_SLICES; k++) begin
			case (k)
				0: begin v_on = 1'b0; a_on = 1'b1; end
				1: begin v_on = 1'b1; a_on = 1'b0; end
				2: begin v_on = 1'b0; a_on = 1'b0; end
				4: begin v_on = 1'($urandom_range(0, 1)); a_on = 1'($urandom_range(0, 1)); end
				default: begin v_on = 1'b1; a_on = 1'b1; end
			endcase
			set_presence(v_on, a_on);
			tx_bursty = ($urandom_range(0, 3) == 0);
			rx_bursty = ($urandom_range(0, 3) == 0);
			if (k == NUM_SLICES - 1)
				cut = stream_bytes.size();
			else
				cut = directed_len + (random_end - directed_len) * (k + 1) / (NUM_SLICES - 1);
			feed_until(cut);
			settle(3);
		end
		repeat (10) @(posedge clk);

		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
